// ===== rtl/three_phase_sine_pwm_duty_macros.svh =====
// Assertion macros used by the three-phase sine duty RTL.
`ifndef THREE_PHASE_SINE_PWM_DUTY_MACROS_SVH
`define THREE_PHASE_SINE_PWM_DUTY_MACROS_SVH

// Implication checked on every rising edge of clk_i, off while rst_ni is low.
`define TPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while rst_ni is low.
`define TPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tps_pwm_pkg.sv =====
// Constants, sine table and lookup helpers for the three-phase sine duty synthesizer.
package tps_pwm_pkg;

  localparam int unsigned SineEntries   = 64;
  localparam int unsigned StoredSamples = 64;
  localparam int unsigned IdxW          = $clog2(StoredSamples);
  localparam int unsigned PhaseW        = 16;
  localparam int unsigned DutyW         = 10;
  localparam int unsigned DutyShift     = 6;
  localparam int unsigned AddrW         = 3;

  localparam logic [PhaseW-1:0] Offset120     = 16'h5555;
  localparam logic [PhaseW-1:0] Offset240     = 16'hAAAA;
  localparam logic [PhaseW-1:0] DutyOffset    = 16'd32767;
  localparam logic [PhaseW-1:0] IncrementRst  = 16'd65;

  typedef enum logic [0:0] {
    RegPhaseIncrement = 1'b0,
    RegUnused         = 1'b1
  } reg_idx_e;

  typedef logic signed [15:0] sample_t;

  localparam sample_t SineTable [StoredSamples] = '{
         16'sd0,   16'sd3212,   16'sd6393,   16'sd9512,
     16'sd12539,  16'sd15446,  16'sd18204,  16'sd20787,
     16'sd23170,  16'sd25329,  16'sd27245,  16'sd28898,
     16'sd30273,  16'sd31356,  16'sd32137,  16'sd32609,
     16'sd32767,  16'sd32609,  16'sd32137,  16'sd31356,
     16'sd30273,  16'sd28898,  16'sd27245,  16'sd25329,
     16'sd23170,  16'sd20787,  16'sd18204,  16'sd15446,
     16'sd12539,   16'sd9512,   16'sd6393,   16'sd3212,
         16'sd0,  -16'sd3212,  -16'sd6393,  -16'sd9512,
    -16'sd12539, -16'sd15446, -16'sd18204, -16'sd20787,
    -16'sd23170, -16'sd25329, -16'sd27245, -16'sd28898,
    -16'sd30273, -16'sd31356, -16'sd32137, -16'sd32609,
    -16'sd32767, -16'sd32609, -16'sd32137, -16'sd31356,
    -16'sd30273, -16'sd28898, -16'sd27245, -16'sd25329,
    -16'sd23170, -16'sd20787, -16'sd18204, -16'sd15446,
    -16'sd12539,  -16'sd9512,  -16'sd6393,  -16'sd3212
  };

  // Scales a phase to a table slot. All factors are constants, so this folds
  // down to a bit-select of the phase when the entry count is a power of two.
  function automatic logic [IdxW-1:0] sine_index(logic [PhaseW-1:0] phase);
    logic [31:0] idx;
    logic [31:0] stored;
    idx    = (32'(phase) * 32'(SineEntries)) >> PhaseW;
    stored = (idx * 32'(StoredSamples)) / SineEntries;
    return stored[IdxW-1:0];
  endfunction

  // The offset sum stays in 0..65534, so it fits the phase width unsigned.
  function automatic logic [DutyW-1:0] duty_of(sample_t sample);
    logic [PhaseW-1:0] sum;
    sum = DutyOffset + PhaseW'(sample);
    return sum[DutyShift +: DutyW];
  endfunction

endpackage

// ===== rtl/three_phase_sine_pwm_duty.sv =====
// Three-phase sine PWM duty synthesizer: phase accumulator, sine ROM and output stage.
//
//   channel   direction   handshake                   payload
//   in        sink        in_valid_i / in_stall_o     advance_i
//   out       source      out_valid_o / out_stall_i   duty_a_o, duty_b_o, duty_c_o, phase_now_o
//   config    APB slave   psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// One transaction is accepted per cycle while in_stall_o is low; each result
// passes through the registered sine ROM read and then the output register.
// The phase accumulator updates in the accept cycle, so back-to-back ticks
// see each other's advance without waiting. Reset clears the phase to zero
// and loads the increment with 65. A stalled output holds the pipeline; input
// is still taken while the ROM stage is free.
module three_phase_sine_pwm_duty (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [tps_pwm_pkg::AddrW-1:0]         paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  advance_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [tps_pwm_pkg::DutyW-1:0]         duty_a_o,
  output logic [tps_pwm_pkg::DutyW-1:0]         duty_b_o,
  output logic [tps_pwm_pkg::DutyW-1:0]         duty_c_o,
  output logic [tps_pwm_pkg::PhaseW-1:0]        phase_now_o
);

  logic [tps_pwm_pkg::PhaseW-1:0] increment_q;
  logic [tps_pwm_pkg::PhaseW-1:0] phase_q, phase_d;
  logic                           s1_valid_q;
  logic [tps_pwm_pkg::PhaseW-1:0] s1_phase_q;
  tps_pwm_pkg::sample_t           s1_samp_a_q, s1_samp_b_q, s1_samp_c_q;
  logic                           out_valid_q;
  logic [tps_pwm_pkg::DutyW-1:0]  duty_a_q, duty_b_q, duty_c_q;
  logic [tps_pwm_pkg::PhaseW-1:0] phase_now_q;
  logic                           move;
  logic                           in_accept;
  logic                           cfg_write;
  tps_pwm_pkg::reg_idx_e          reg_idx;

  assign reg_idx   = tps_pwm_pkg::reg_idx_e'(paddr[2]);
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      tps_pwm_pkg::RegPhaseIncrement: prdata = 32'(increment_q);
      default:                        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      increment_q <= tps_pwm_pkg::IncrementRst;
    end else if (cfg_write && reg_idx == tps_pwm_pkg::RegPhaseIncrement) begin
      increment_q <= pwdata[tps_pwm_pkg::PhaseW-1:0];
    end
  end

  // The output register moves when it is empty or its transaction completes.
  assign move       = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !move;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    phase_d = phase_q;
    if (in_accept && advance_i) begin
      phase_d = phase_q + increment_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (!s1_valid_q || move) begin
        s1_valid_q <= in_accept;
      end
      if (move) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Sine ROM with registered read data, one read per phase.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_phase_q  <= phase_d;
      s1_samp_a_q <= tps_pwm_pkg::SineTable[tps_pwm_pkg::sine_index(phase_d)];
      s1_samp_b_q <= tps_pwm_pkg::SineTable[
                       tps_pwm_pkg::sine_index(phase_d + tps_pwm_pkg::Offset120)];
      s1_samp_c_q <= tps_pwm_pkg::SineTable[
                       tps_pwm_pkg::sine_index(phase_d + tps_pwm_pkg::Offset240)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (move && s1_valid_q) begin
      duty_a_q    <= tps_pwm_pkg::duty_of(s1_samp_a_q);
      duty_b_q    <= tps_pwm_pkg::duty_of(s1_samp_b_q);
      duty_c_q    <= tps_pwm_pkg::duty_of(s1_samp_c_q);
      phase_now_q <= s1_phase_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign duty_a_o    = duty_a_q;
  assign duty_b_o    = duty_b_q;
  assign duty_c_o    = duty_c_q;
  assign phase_now_o = phase_now_q;

`include "three_phase_sine_pwm_duty_macros.svh"

  `TPS_ASSERT_IMP(a_stall_only_when_full, in_stall_o, s1_valid_q && out_valid_q && out_stall_i, "input stalled while the pipeline has room")
  `TPS_ASSERT_NEXT(a_phase_advances, in_accept && advance_i, phase_q == $past(phase_q + increment_q), "phase did not advance by the increment")
  `TPS_ASSERT_NEXT(a_phase_holds, !(in_accept && advance_i), $stable(phase_q), "phase changed without an advancing transaction")
  `TPS_ASSERT_NEXT(a_out_phase_follows, move && s1_valid_q, out_valid_o && phase_now_o == $past(s1_phase_q), "output phase does not match the ROM stage")

endmodule
